/* rtl/core/fgw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_pkg
// Shared types and constants of the Fourier gait waveform generator.
// ----------------------------------------------------------------------------
package fgw_pkg;

   // action codes as they arrive on the request channel
   typedef enum logic [1:0] {
      ACT_LOAD_COEF = 2'd0,
      ACT_LOAD_AMP  = 2'd1,
      ACT_NORMALIZE = 2'd2,
      ACT_EVALUATE  = 2'd3
   } action_type;

   // classified command handed from the front to the back
   typedef struct packed {
      action_type         kind;
      logic               write_ok;
      logic [2:0]         module_sel;
      logic [2:0]         harmonic_sel;
      logic signed [15:0] sine_weight;
      logic signed [15:0] cosine_weight;
      logic signed [15:0] amplitude_value;
      logic [31:0]        elapsed_us;
   } cmd_type;

   // back-end sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOD_START,
      ST_SERIES_START,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_ACC,
      ST_SERIES_DONE,
      ST_SCAN_NEXT,
      ST_SCALE,
      ST_DIV_GO,
      ST_DIV,
      ST_EMIT
   } state_type;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // datapath widths
   localparam int ACC_W    = 40;
   localparam int SERIES_W = 24;
   localparam int PEAK_W   = 24;
   localparam int PROD_W   = 40;
   localparam int WAVE_W   = 17;

   // quarter-wave sine polynomial, q15
   localparam logic [16:0] SIN_A = 17'd51472;
   localparam logic [16:0] SIN_B = 17'd21024;
   localparam logic [16:0] SIN_C = 17'd2320;
   localparam logic [16:0] SIN_MAX = 17'd32767;
   localparam logic [16:0] X_ONE   = 17'd32768;

   // peak factor after reset: one in series units
   localparam logic [PEAK_W-1:0] PEAK_ONE = 24'd16384;

   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

endpackage

/* rtl/core/fourier_gait_waveform_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_gait_waveform_generator_core
// Per-module truncated Fourier series oscillator with peak normalization.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall action, selects, weights, amplitude, time
//   rsp      out  rsp_valid/rsp_stall module_index, drive, zero_peak, last
//   csr      in   csr_wen             phase_per_microsecond
//
// Load actions pass through decode straight to the result register. Evaluate
// time is set by the shared sine polynomial multiplier, run for the sine and
// cosine term of each harmonic, and by the 40-step drive divider. Normalize
// runs the full series at every scan point of every module.
// Synchronous reset sets the frequency register to 4295 and all peaks to one.
// A stalled result beat holds the back end; two further requests queue.
// ----------------------------------------------------------------------------
module fourier_gait_waveform_generator_core
   import fgw_pkg::*;
#(
   parameter int MODULES     = 8,
   parameter int HARMONICS   = 8,
   parameter int SCAN_POINTS = 1024,
   parameter int PHASE_BITS  = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [2:0]         req_module_select,
   input  logic [2:0]         req_harmonic_select,
   input  logic signed [15:0] req_sine_weight,
   input  logic signed [15:0] req_cosine_weight,
   input  logic signed [15:0] req_amplitude_value,
   input  logic [31:0]        req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_module_index,
   output logic signed [15:0] rsp_drive,
   output logic               rsp_zero_peak,
   output logic               rsp_last,
   input  logic               csr_wen,
   input  logic [31:0]        csr_wdata
);

   logic [31:0] phase_per_us_ff;
   logic        push;
   logic        pop;
   logic        full;
   logic        empty;
   cmd_type     push_cmd;
   cmd_type     head;

   // frequency register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_per_us_ff <= 32'd4295;
      end else if (csr_wen) begin
         phase_per_us_ff <= csr_wdata;
      end
   end

   fgw_front #(
      .MODULES   (MODULES),
      .HARMONICS (HARMONICS)
   ) u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_module_select   (req_module_select),
      .req_harmonic_select (req_harmonic_select),
      .req_sine_weight     (req_sine_weight),
      .req_cosine_weight   (req_cosine_weight),
      .req_amplitude_value (req_amplitude_value),
      .req_elapsed_us      (req_elapsed_us),
      .queue_full          (full),
      .push                (push),
      .cmd                 (push_cmd)
   );

   fgw_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   fgw_back #(
      .MODULES     (MODULES),
      .HARMONICS   (HARMONICS),
      .SCAN_POINTS (SCAN_POINTS),
      .PHASE_BITS  (PHASE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .phase_per_us     (phase_per_us_ff),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_module_index (rsp_module_index),
      .rsp_drive        (rsp_drive),
      .rsp_zero_peak    (rsp_zero_peak),
      .rsp_last         (rsp_last)
   );

endmodule

/* rtl/core/fgw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/fgw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_front
// Request intake: takes a beat, checks selector ranges, pushes a command.
// ----------------------------------------------------------------------------
module fgw_front
   import fgw_pkg::*;
#(
   parameter int MODULES   = 8,
   parameter int HARMONICS = 8
) (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [2:0]         req_module_select,
   input  logic [2:0]         req_harmonic_select,
   input  logic signed [15:0] req_sine_weight,
   input  logic signed [15:0] req_cosine_weight,
   input  logic signed [15:0] req_amplitude_value,
   input  logic [31:0]        req_elapsed_us,
   input  logic               queue_full,
   output logic               push,
   output cmd_type            cmd
);

   logic module_ok;
   logic harmonic_ok;

   assign module_ok   = int'(req_module_select) < MODULES;
   assign harmonic_ok = int'(req_harmonic_select) < HARMONICS;

   // classify the beat
   always_comb begin
      cmd.kind            = action_type'(req_action);
      cmd.module_sel      = req_module_select;
      cmd.harmonic_sel    = req_harmonic_select;
      cmd.sine_weight     = req_sine_weight;
      cmd.cosine_weight   = req_cosine_weight;
      cmd.amplitude_value = req_amplitude_value;
      cmd.elapsed_us      = req_elapsed_us;
      case (action_type'(req_action))
         ACT_LOAD_COEF: cmd.write_ok = module_ok && harmonic_ok;
         ACT_LOAD_AMP:  cmd.write_ok = module_ok;
         default:       cmd.write_ok = 1'b0;
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* rtl/core/fgw_cmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_cmd_queue
// Short command queue decoupling request intake from execution.
// ----------------------------------------------------------------------------
module fgw_cmd_queue
   import fgw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

endmodule

/* rtl/core/fgw_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgw_divider
   import fgw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [PEAK_W-1:0] divisor,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(PROD_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PEAK_W-1:0] rem_ff;
   logic [PROD_W-1:0] quo_ff;
   logic [PEAK_W-1:0] div_ff;
   logic [PEAK_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift-subtract datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? PEAK_W'(trial - {1'b0, div_ff}) : trial[PEAK_W-1:0];
         quo_ff <= {quo_ff[PROD_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/fgw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_back
// Execution engine: coefficient store, series sequencer, peak scan,
// drive scaling and the result register.
// ----------------------------------------------------------------------------
module fgw_back
   import fgw_pkg::*;
#(
   parameter int MODULES     = 8,
   parameter int HARMONICS   = 8,
   parameter int SCAN_POINTS = 1024,
   parameter int PHASE_BITS  = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        phase_per_us,
   input  cmd_type            head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_module_index,
   output logic signed [15:0] rsp_drive,
   output logic               rsp_zero_peak,
   output logic               rsp_last
);

   localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
   localparam int KW    = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
   localparam int PW    = $clog2(SCAN_POINTS);
   localparam int DEPTH = MODULES * HARMONICS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [63:0] SCAN_FULL = 64'd1 << 32;
   localparam logic [31:0] SCAN_STEP = 32'(SCAN_FULL / SCAN_POINTS);
   localparam logic [PW:0] SCAN_REM  = (PW + 1)'(SCAN_FULL % SCAN_POINTS);
   localparam logic [PW:0] SCAN_DIV  = (PW + 1)'(SCAN_POINTS);

   state_type state_ff, state_in;
   cmd_type   cmd_ff;

   logic [MW-1:0]              m_ff;
   logic [KW-1:0]              k_ff;
   logic                       cos_ff;
   logic [31:0]                base_ph_ff;
   logic [31:0]                hph_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [16:0]                x_ff;
   logic [16:0]                x2_ff;
   logic [16:0]                t_ff;
   logic                       neg_ff;
   logic signed [WAVE_W-1:0]   wave_ff;
   logic signed [SERIES_W-1:0] series_ff;
   logic [PW-1:0]              pt_ff;
   logic [31:0]                scan_ph_ff;
   logic [PW-1:0]              rem_ff;
   logic [PEAK_W-1:0]          peak_run_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [PEAK_W-1:0]          peak_ff [MODULES];
   logic signed [15:0]         amp_ff [MODULES];

   logic [2:0]                 res_module_ff;
   logic signed [15:0]         res_drive_ff;
   logic                       res_zero_ff;
   logic                       res_last_ff;

   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_module_ff;
   logic signed [15:0]         rsp_drive_ff;
   logic                       rsp_zero_ff;
   logic                       rsp_last_ff;

   logic                       ram_we;
   logic                       div_start;
   logic                       div_done;
   logic [PROD_W-1:0]          div_quot;
   logic                       emit;
   logic                       out_free;
   logic                       m_last;
   logic                       is_eval;

   logic [AW-1:0]              ram_waddr;
   logic [AW-1:0]              ram_raddr;
   logic [31:0]                ram_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign m_last   = m_ff == MW'(MODULES - 1);
   assign is_eval  = cmd_ff.kind == ACT_EVALUATE;

   // coefficient store: sine weight in the upper half, cosine in the lower
   assign ram_waddr = AW'(int'(cmd_ff.module_sel) * HARMONICS + int'(cmd_ff.harmonic_sel));
   assign ram_raddr = AW'(int'(m_ff) * HARMONICS + int'(k_ff));

   fgw_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_coef_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({cmd_ff.sine_weight, cmd_ff.cosine_weight}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sine argument and quadrant folding
   logic [31:0]           phase_sel;
   logic [PHASE_BITS-1:0] idx;
   logic [16:0]           x_raw;
   logic [16:0]           x_calc;

   assign phase_sel = cos_ff ? hph_ff + QUARTER_TURN : hph_ff;
   assign idx       = phase_sel[31 -: PHASE_BITS];
   assign x_raw     = 17'(idx[PHASE_BITS-3:0]) << (17 - PHASE_BITS);
   assign x_calc    = idx[PHASE_BITS-2] ? X_ONE - x_raw : x_raw;

   // shared polynomial multiplier
   logic [16:0] mul_a;
   logic [16:0] mul_b;
   logic [33:0] mul_p;
   logic [16:0] mul_q15;

   always_comb begin
      case (state_ff)
         ST_P0: begin
            mul_a = x_calc;
            mul_b = x_calc;
         end
         ST_P1: begin
            mul_a = SIN_C;
            mul_b = x2_ff;
         end
         ST_P2: begin
            mul_a = t_ff;
            mul_b = x2_ff;
         end
         default: begin
            mul_a = t_ff;
            mul_b = x_ff;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign mul_q15 = mul_p[31:15];

   // weighted term
   logic signed [15:0]         coef_sel;
   logic signed [32:0]         term_p;
   logic signed [ACC_W-1:0]    acc_bias;
   logic signed [ACC_W-1:0]    acc_shift;
   logic [PEAK_W-1:0]          series_abs;
   logic [PEAK_W-1:0]          peak_new;
   logic [16:0]                t_clamp;

   assign coef_sel   = cos_ff ? $signed(ram_rdata[15:0]) : $signed(ram_rdata[31:16]);
   assign term_p     = coef_sel * wave_ff;
   assign acc_bias   = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
   assign acc_shift  = acc_bias >>> 15;
   assign series_abs = series_ff[SERIES_W-1] ? PEAK_W'(-series_ff) : PEAK_W'(series_ff);
   assign peak_new   = (series_abs > peak_run_ff) ? series_abs : peak_run_ff;
   assign t_clamp    = (mul_q15 > SIN_MAX) ? SIN_MAX : mul_q15;

   // scan phase step: floor(i * 2^32 / points) kept incrementally
   logic [PW:0]  rem_sum;
   logic         rem_carry;
   logic [31:0]  scan_next;

   assign rem_sum   = {1'b0, rem_ff} + SCAN_REM;
   assign rem_carry = rem_sum >= SCAN_DIV;
   assign scan_next = scan_ph_ff + SCAN_STEP + 32'(rem_carry);

   // evaluate phase and drive saturation
   logic [63:0]        eval_ph;
   logic [PROD_W-1:0]  prod_mag;
   logic signed [15:0] drive_sat;

   assign eval_ph  = cmd_ff.elapsed_us * phase_per_us;
   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   always_comb begin
      if (!prod_ff[PROD_W-1]) begin
         drive_sat = (div_quot > PROD_W'(32767)) ? 16'sh7FFF : $signed(div_quot[15:0]);
      end else begin
         drive_sat = (div_quot > PROD_W'(32768)) ? 16'sh8000 : $signed(-div_quot[15:0]);
      end
   end

   fgw_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag),
      .divisor  (peak_ff[m_ff]),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and strobes
   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff.kind)
               ACT_LOAD_COEF: begin
                  ram_we   = cmd_ff.write_ok;
                  state_in = ST_EMIT;
               end
               ACT_LOAD_AMP: state_in = ST_EMIT;
               default:      state_in = ST_MOD_START;
            endcase
         end
         ST_MOD_START: begin
            state_in = (is_eval && peak_ff[m_ff] == '0) ? ST_EMIT : ST_SERIES_START;
         end
         ST_SERIES_START: state_in = ST_P0;
         ST_P0:           state_in = ST_P1;
         ST_P1:           state_in = ST_P2;
         ST_P2:           state_in = ST_P3;
         ST_P3:           state_in = ST_ACC;
         ST_ACC: begin
            state_in = (cos_ff && k_ff == KW'(HARMONICS - 1)) ? ST_SERIES_DONE : ST_P0;
         end
         ST_SERIES_DONE: state_in = is_eval ? ST_SCALE : ST_SCAN_NEXT;
         ST_SCAN_NEXT: begin
            state_in = (pt_ff == PW'(SCAN_POINTS - 1)) ? ST_EMIT : ST_SERIES_START;
         end
         ST_SCALE: state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = res_last_ff ? ST_IDLE : ST_MOD_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // per-module peak factors
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODULES; i++) begin
            peak_ff[i] <= PEAK_ONE;
         end
      end else if (state_ff == ST_SCAN_NEXT && pt_ff == PW'(SCAN_POINTS - 1)) begin
         peak_ff[m_ff] <= peak_new;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head;
      end
      case (state_ff)
         ST_DECODE: begin
            m_ff          <= '0;
            base_ph_ff    <= eval_ph[31:0];
            res_module_ff <= cmd_ff.module_sel;
            res_drive_ff  <= '0;
            res_zero_ff   <= 1'b0;
            res_last_ff   <= 1'b1;
            if (cmd_ff.kind == ACT_LOAD_AMP && cmd_ff.write_ok) begin
               amp_ff[MW'(cmd_ff.module_sel)] <= cmd_ff.amplitude_value;
            end
         end
         ST_MOD_START: begin
            pt_ff         <= '0;
            scan_ph_ff    <= '0;
            rem_ff        <= '0;
            peak_run_ff   <= '0;
            res_module_ff <= 3'(m_ff);
            res_drive_ff  <= '0;
            res_zero_ff   <= 1'b1;
            res_last_ff   <= m_last;
            if (!is_eval) begin
               base_ph_ff <= '0;
            end
         end
         ST_SERIES_START: begin
            k_ff   <= '0;
            cos_ff <= 1'b0;
            hph_ff <= '0;
            acc_ff <= '0;
         end
         ST_P0: begin
            x_ff   <= x_calc;
            x2_ff  <= mul_q15;
            neg_ff <= idx[PHASE_BITS-1];
         end
         ST_P1: t_ff <= SIN_B - mul_q15;
         ST_P2: t_ff <= SIN_A - mul_q15;
         ST_P3: wave_ff <= neg_ff ? -$signed(t_clamp) : $signed(t_clamp);
         ST_ACC: begin
            acc_ff <= acc_ff + ACC_W'(term_p);
            cos_ff <= !cos_ff;
            if (cos_ff) begin
               k_ff   <= k_ff + 1'b1;
               hph_ff <= hph_ff + base_ph_ff;
            end
         end
         ST_SERIES_DONE: series_ff <= SERIES_W'(acc_shift);
         ST_SCAN_NEXT: begin
            peak_run_ff   <= peak_new;
            pt_ff         <= pt_ff + 1'b1;
            scan_ph_ff    <= scan_next;
            base_ph_ff    <= scan_next;
            rem_ff        <= rem_carry ? PW'(rem_sum - SCAN_DIV) : PW'(rem_sum);
            res_module_ff <= 3'(m_ff);
            res_drive_ff  <= '0;
            res_zero_ff   <= peak_new == '0;
            res_last_ff   <= m_last;
         end
         ST_SCALE: prod_ff <= amp_ff[m_ff] * series_ff;
         ST_DIV: begin
            if (div_done) begin
               res_module_ff <= 3'(m_ff);
               res_drive_ff  <= drive_sat;
               res_zero_ff   <= 1'b0;
               res_last_ff   <= m_last;
            end
         end
         ST_EMIT: begin
            if (emit && !res_last_ff) begin
               m_ff <= m_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result register: one beat held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_module_ff <= res_module_ff;
         rsp_drive_ff  <= res_drive_ff;
         rsp_zero_ff   <= res_zero_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_module_index = rsp_module_ff;
   assign rsp_drive        = rsp_drive_ff;
   assign rsp_zero_peak    = rsp_zero_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* rtl/core/fgw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgw_checker
// Port-level checks on the result channel of the waveform generator.
// ----------------------------------------------------------------------------
module fgw_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_module_index,
   input logic signed [15:0] rsp_drive,
   input logic               rsp_zero_peak,
   input logic               rsp_last
);

   // a stalled beat keeps its drive, module index and last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_module_index) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // a zero peak always forces a zero drive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_peak |-> rsp_drive == 16'sd0)
      else $error("zero peak with nonzero drive");

   // no result beat right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fourier_gait_waveform_generator_core fgw_checker u_fgw_checker (.*);
